### hdl/m3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse core.
package m3i_pkg;

    localparam int ELEM_W        = 32;
    localparam int N_ELEM        = 9;
    localparam int N_DIM         = 3;
    localparam int HALF_W        = 32;
    localparam int COF_W         = 64;
    localparam int DET_W         = 98;
    localparam int DMAG_W        = 97;
    // quotient of 2N/D kept to bit Q_TOP; bit Q_TOP set means overflow
    localparam int Q_TOP         = 34;
    localparam int CMP_W         = DMAG_W + Q_TOP + 1;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;

    typedef logic [N_ELEM-1:0][ELEM_W-1:0] mat_t;

    typedef struct packed {
        logic [N_ELEM-1:0][COF_W-1:0]  cof;
        logic [N_DIM-1:0][ELEM_W-1:0]  row1;
    } cof_bus_t;

    typedef struct packed {
        logic [DMAG_W-1:0]             dmag;
        logic                          zero;
        logic [N_ELEM-1:0]             neg;
        logic [N_ELEM-1:0][COF_W-1:0]  mag;
    } div_in_t;

    typedef struct packed {
        logic                          zero;
        logic [N_ELEM-1:0]             neg;
        logic [N_ELEM-1:0][Q_TOP:0]    quo;
    } div_out_t;

endpackage

### hdl/m3i_cofactor.sv
// Two-stage pipeline: minor products, then signed cofactors.
module m3i_cofactor
    import m3i_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     vld_in,
    output logic     rdy_in,
    input  mat_t     mat_in,
    output logic     vld_out,
    input  logic     rdy_out,
    output cof_bus_t cof_out
);

    localparam int NSTG = 2;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   en;

    logic signed [COF_W-1:0] p0_reg [N_ELEM];
    logic signed [COF_W-1:0] p1_reg [N_ELEM];
    logic [N_ELEM-1:0][COF_W-1:0]  cof_reg;
    logic [N_DIM-1:0][ELEM_W-1:0]  row1_s1_reg;
    logic [N_DIM-1:0][ELEM_W-1:0]  row1_s2_reg;

    assign en[NSTG] = rdy_out;
    for (genvar s = 0; s < NSTG; s++) begin : g_en
        assign en[s] = !vld_reg[s] || en[s+1];
    end
    assign rdy_in  = en[0];
    assign vld_out = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (en[0]) vld_reg[0] <= vld_in;
            if (en[1]) vld_reg[1] <= vld_reg[0];
        end
    end

    for (genvar i = 0; i < N_DIM; i++) begin : g_row
        for (genvar j = 0; j < N_DIM; j++) begin : g_col
            localparam int R0  = (i == 0) ? 1 : 0;
            localparam int R1  = (i == 2) ? 1 : 2;
            localparam int C0  = (j == 0) ? 1 : 0;
            localparam int C1  = (j == 2) ? 1 : 2;
            localparam int K   = i * N_DIM + j;
            localparam bit ODD = ((i + j) % 2) == 1;

            logic signed [COF_W-1:0] p0_next;
            logic signed [COF_W-1:0] p1_next;

            assign p0_next = $signed(mat_in[R0*N_DIM+C0]) * $signed(mat_in[R1*N_DIM+C1]);
            assign p1_next = $signed(mat_in[R0*N_DIM+C1]) * $signed(mat_in[R1*N_DIM+C0]);

            always_ff @(posedge clk) begin
                if (en[0]) begin
                    p0_reg[K] <= p0_next;
                    p1_reg[K] <= p1_next;
                end
                // checkerboard sign folded into the operand order
                if (en[1]) begin
                    cof_reg[K] <= ODD ? p1_reg[K] - p0_reg[K] : p0_reg[K] - p1_reg[K];
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en[0]) row1_s1_reg <= mat_in[N_DIM-1:0];
        if (en[1]) row1_s2_reg <= row1_s1_reg;
    end

    assign cof_out.cof  = cof_reg;
    assign cof_out.row1 = row1_s2_reg;

endmodule

### hdl/m3i_det.sv
// Four-stage determinant pipeline; also forms divider operands (transposed cofactors).
module m3i_det
    import m3i_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     vld_in,
    output logic     rdy_in,
    input  cof_bus_t cof_in,
    output logic     vld_out,
    input  logic     rdy_out,
    output div_in_t  div_out
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   en;

    logic signed [COF_W:0]      lo_reg   [N_DIM];
    logic signed [COF_W-1:0]    hi_reg   [N_DIM];
    logic signed [DET_W-1:0]    term_reg [N_DIM];
    logic signed [DET_W-1:0]    det_reg;
    logic [N_ELEM-1:0][COF_W-1:0] cof_a_reg;
    logic [N_ELEM-1:0][COF_W-1:0] cof_b_reg;
    logic [N_ELEM-1:0][COF_W-1:0] cof_c_reg;
    div_in_t                    out_reg;
    div_in_t                    out_next;

    assign en[NSTG] = rdy_out;
    for (genvar s = 0; s < NSTG; s++) begin : g_en
        assign en[s] = !vld_reg[s] || en[s+1];
    end
    assign rdy_in  = en[0];
    assign vld_out = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (en[0]) vld_reg[0] <= vld_in;
            for (int s = 1; s < NSTG; s++) begin
                if (en[s]) vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // a1j * C1j split into two partial products over the 32-bit halves of C1j
    for (genvar j = 0; j < N_DIM; j++) begin : g_term
        logic signed [COF_W:0]   lo_next;
        logic signed [COF_W-1:0] hi_next;
        logic signed [DET_W-1:0] term_next;

        assign lo_next = $signed(cof_in.row1[j]) *
                         $signed({1'b0, cof_in.cof[j][HALF_W-1:0]});
        assign hi_next = $signed(cof_in.row1[j]) * $signed(cof_in.cof[j][COF_W-1:HALF_W]);
        assign term_next = (DET_W'(hi_reg[j]) <<< HALF_W) + DET_W'(lo_reg[j]);

        always_ff @(posedge clk) begin
            if (en[0]) begin
                lo_reg[j] <= lo_next;
                hi_reg[j] <= hi_next;
            end
            if (en[1]) term_reg[j] <= term_next;
        end
    end

    always_comb begin
        logic                    det_neg;
        logic signed [COF_W-1:0] c;
        det_neg       = det_reg[DET_W-1];
        out_next.zero = (det_reg == '0);
        out_next.dmag = det_neg ? DMAG_W'(-det_reg) : DMAG_W'(det_reg);
        for (int i = 0; i < N_DIM; i++) begin
            for (int j = 0; j < N_DIM; j++) begin
                // b_ij takes C_ji
                c = $signed(cof_c_reg[j*N_DIM+i]);
                out_next.mag[i*N_DIM+j] = c[COF_W-1] ? COF_W'(-c) : COF_W'(c);
                out_next.neg[i*N_DIM+j] = c[COF_W-1] ^ det_neg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en[0]) cof_a_reg <= cof_in.cof;
        if (en[1]) cof_b_reg <= cof_a_reg;
        if (en[2]) begin
            cof_c_reg <= cof_b_reg;
            det_reg   <= term_reg[0] + term_reg[1] + term_reg[2];
        end
        if (en[3]) out_reg <= out_next;
    end

    assign div_out = out_reg;

endmodule

### hdl/m3i_divider.sv
// Nine-lane restoring divider, one quotient bit of 2*|C|*2^(2F)/|det| per stage.
module m3i_divider
    import m3i_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     vld_in,
    output logic     rdy_in,
    input  div_in_t  div_in,
    output logic     vld_out,
    input  logic     rdy_out,
    output div_out_t div_out
);

    localparam int NSTG = Q_TOP + 1;
    localparam int NUM_SH = 2 * FRAC_BITS + 1;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   en;

    logic [CMP_W-1:0]  rem_reg  [NSTG][N_ELEM];
    logic [Q_TOP:0]    quo_reg  [NSTG][N_ELEM];
    logic [N_ELEM-1:0] neg_reg  [NSTG];
    logic              zero_reg [NSTG];
    logic [DMAG_W-1:0] dmag_reg [NSTG];

    assign en[NSTG] = rdy_out;
    for (genvar s = 0; s < NSTG; s++) begin : g_en
        assign en[s] = !vld_reg[s] || en[s+1];
    end
    assign rdy_in  = en[0];
    assign vld_out = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (en[0]) vld_reg[0] <= vld_in;
            for (int s = 1; s < NSTG; s++) begin
                if (en[s]) vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        localparam int K = Q_TOP - g;

        logic [CMP_W-1:0]  rem_src [N_ELEM];
        logic [Q_TOP:0]    quo_src [N_ELEM];
        logic [N_ELEM-1:0] neg_src;
        logic              zero_src;
        logic [DMAG_W-1:0] dmag_src;
        logic [CMP_W-1:0]  dsh;

        if (g == 0) begin : g_first
            for (genvar l = 0; l < N_ELEM; l++) begin : g_ld
                assign rem_src[l] = CMP_W'(div_in.mag[l]) << NUM_SH;
                assign quo_src[l] = '0;
            end
            assign neg_src  = div_in.neg;
            assign zero_src = div_in.zero;
            assign dmag_src = div_in.dmag;
        end
        else begin : g_next
            for (genvar l = 0; l < N_ELEM; l++) begin : g_ld
                assign rem_src[l] = rem_reg[g-1][l];
                assign quo_src[l] = quo_reg[g-1][l];
            end
            assign neg_src  = neg_reg[g-1];
            assign zero_src = zero_reg[g-1];
            assign dmag_src = dmag_reg[g-1];
        end

        assign dsh = CMP_W'(dmag_src) << K;

        for (genvar l = 0; l < N_ELEM; l++) begin : g_lane
            logic ge;
            logic [Q_TOP:0] quo_next;

            assign ge = rem_src[l] >= dsh;
            always_comb begin
                quo_next    = quo_src[l];
                quo_next[K] = ge;
            end

            always_ff @(posedge clk) begin
                if (en[g]) begin
                    rem_reg[g][l] <= ge ? rem_src[l] - dsh : rem_src[l];
                    quo_reg[g][l] <= quo_next;
                end
            end
        end

        always_ff @(posedge clk) begin
            if (en[g]) begin
                neg_reg[g]  <= neg_src;
                zero_reg[g] <= zero_src;
                dmag_reg[g] <= dmag_src;
            end
        end
    end

    assign div_out.zero = zero_reg[NSTG-1];
    assign div_out.neg  = neg_reg[NSTG-1];
    for (genvar l = 0; l < N_ELEM; l++) begin : g_out
        assign div_out.quo[l] = quo_reg[NSTG-1][l];
    end

endmodule

### hdl/matrix3x3_inverse_core.sv
// 3x3 Q-format matrix inverse: adjugate over determinant, rounded and saturated.
// Accepts one matrix per clock while the output side keeps up and returns one
// inverse per matrix, in order. The depth is set by two cofactor stages, four
// determinant stages, the 35-stage restoring divider (nine lanes, one quotient
// bit per stage) and the rounding/output register.
// Each stage holds an item only while the stage after it is full, so bubbles
// close up under back-pressure. A zero determinant returns all zeros with
// tuser (singular) set.
module matrix3x3_inverse_core
    import m3i_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [N_ELEM*ELEM_W-1:0] s_axis_tdata,  // a11,a12,a13,a21,..,a33 (32 b each)
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [N_ELEM*ELEM_W-1:0] m_axis_tdata,  // b11,b12,b13,b21,..,b33 (32 b each)
    output logic                     m_axis_tuser   // singular
);

    logic     cof_vld;
    logic     cof_rdy;
    cof_bus_t cof_bus;
    logic     det_vld;
    logic     det_rdy;
    div_in_t  det_bus;
    logic     div_vld;
    logic     out_en;
    div_out_t div_bus;

    logic                           out_vld_reg;
    logic [N_ELEM-1:0][ELEM_W-1:0]  data_reg;
    logic [N_ELEM-1:0][ELEM_W-1:0]  data_next;
    logic                           sing_reg;

    m3i_cofactor u_cof (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (s_axis_tvalid),
        .rdy_in  (s_axis_tready),
        .mat_in  (mat_t'(s_axis_tdata)),
        .vld_out (cof_vld),
        .rdy_out (cof_rdy),
        .cof_out (cof_bus)
    );

    m3i_det u_det (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (cof_vld),
        .rdy_in  (cof_rdy),
        .cof_in  (cof_bus),
        .vld_out (det_vld),
        .rdy_out (det_rdy),
        .div_out (det_bus)
    );

    m3i_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (det_vld),
        .rdy_in  (det_rdy),
        .div_in  (det_bus),
        .vld_out (div_vld),
        .rdy_out (out_en),
        .div_out (div_bus)
    );

    assign out_en = !out_vld_reg || m_axis_tready;

    // round half away from zero: q = (floor(2N/D) + 1) / 2, then saturate
    for (genvar l = 0; l < N_ELEM; l++) begin : g_rnd
        logic [Q_TOP:0]   rnd;
        logic [Q_TOP-1:0] qr;
        logic [Q_TOP-1:0] qneg;

        assign rnd  = {1'b0, div_bus.quo[l][Q_TOP-1:0]} + (Q_TOP+1)'(1);
        assign qr   = rnd[Q_TOP:1];
        assign qneg = '0 - qr;

        always_comb begin
            if (div_bus.zero) begin
                data_next[l] = '0;
            end
            else if (div_bus.quo[l][Q_TOP]) begin
                data_next[l] = div_bus.neg[l] ? ELEM_MIN : ELEM_MAX;
            end
            else if (div_bus.neg[l]) begin
                data_next[l] = (qr > Q_TOP'(ELEM_MIN)) ? ELEM_MIN : qneg[ELEM_W-1:0];
            end
            else begin
                data_next[l] = (qr > Q_TOP'(ELEM_MAX)) ? ELEM_MAX : qr[ELEM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end
        else if (out_en) begin
            out_vld_reg <= div_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (out_en) begin
            data_reg <= data_next;
            sing_reg <= div_bus.zero;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = sing_reg;

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("singular result with nonzero elements");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        div_vld && out_en |=> m_axis_tvalid)
        else $error("divider result lost at output register");

endmodule

### tb/matrix3x3_inverse_core_tb.sv
// Testbench for the 3x3 matrix inverse core: predicts each inverse and checks it in order.
class inverse_scoreboard;
    logic [287:0] inv_q[$];
    logic         sing_q[$];
    int           errors = 0;

    // Rounded, saturated quotient of cof * 2^(2F) / det, det nonzero.
    function automatic logic [31:0] quotient(logic signed [63:0] cof,
                                             logic signed [127:0] det);
        logic [127:0] cmag;
        logic [127:0] dmag;
        logic [191:0] num;
        logic [191:0] q;
        logic [191:0] r;
        logic         neg;
        cmag = cof[63] ? -{{64{cof[63]}}, cof} : {64'd0, cof};
        dmag = det[127] ? -det : det;
        neg = cof[63] != det[127];
        num = {64'd0, cmag} << 32;
        q = num / {64'd0, dmag};
        r = num % {64'd0, dmag};
        if ((r << 1) >= {64'd0, dmag})
            q = q + 1;
        if (neg)
        begin
            if (q > 192'h8000_0000)
                return 32'h8000_0000;
            return -q[31:0];
        end
        if (q > 192'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function void note_matrix(logic [287:0] mat);
        logic signed [63:0]  a[3][3];
        logic signed [63:0]  c[3][3];
        logic signed [127:0] det;
        logic [287:0]        inv;
        int r0, r1, c0, c1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = $signed(mat[(i*3+j)*32 +: 32]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                r0 = (i == 0) ? 1 : 0;
                r1 = (i == 2) ? 1 : 2;
                c0 = (j == 0) ? 1 : 0;
                c1 = (j == 2) ? 1 : 2;
                c[i][j] = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
                if ((i + j) % 2)
                    c[i][j] = -c[i][j];
            end
        det = 0;
        for (int j = 0; j < 3; j++)
            det = det + 128'(a[0][j]) * 128'(c[0][j]);
        inv = '0;
        if (det != 0)
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    inv[(i*3+j)*32 +: 32] = quotient(c[j][i], det);
        inv_q.push_back(inv);
        sing_q.push_back(det == 0);
    endfunction

    function void check_inverse(logic [287:0] inv, logic sing);
        logic [287:0] e;
        logic         es;
        if (inv_q.size() == 0)
        begin
            $display("%0t: unexpected result %h sing %b", $time, inv, sing);
            errors++;
            return;
        end
        e = inv_q.pop_front();
        es = sing_q.pop_front();
        for (int k = 0; k < 9; k++)
            if (e[k*32 +: 32] !== inv[k*32 +: 32])
            begin
                $display("%0t: b%0d%0d expected %h actual %h", $time, k/3+1, k%3+1,
                         e[k*32 +: 32], inv[k*32 +: 32]);
                errors++;
            end
        if (es !== sing)
        begin
            $display("%0t: singular expected %b actual %b", $time, es, sing);
            errors++;
        end
    endfunction
endclass

module matrix3x3_inverse_core_tb;
    import m3i_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [287:0] m_axis_tdata;
    logic         m_axis_tuser;

    inverse_scoreboard sb = new();
    bit sink_hold = 0;
    bit sent_all = 0;

    matrix3x3_inverse_core dut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return ELEM_MAX;
            2: return ELEM_MIN;
            3: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
            default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    task automatic send_matrix(logic [287:0] mat, int gap);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= mat;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_matrix(mat);
    endtask

    function automatic logic [287:0] diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
        logic [287:0] m;
        m = '0;
        m[0 +: 32] = d0;
        m[4*32 +: 32] = d1;
        m[8*32 +: 32] = d2;
        return m;
    endfunction

    // Source side
    initial
    begin
        logic [287:0] m;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_matrix(diag(32'h10000, 32'h10000, 32'h10000), 0);
        send_matrix(diag(32'h20000, 32'hFFFF0000, 32'h8000), 0);
        send_matrix('0, 1);
        send_matrix({9{32'h10000}}, 0);
        send_matrix({9{ELEM_MAX}}, 0);
        send_matrix(diag(ELEM_MAX, ELEM_MAX, ELEM_MAX), 0);
        send_matrix(diag(ELEM_MIN, ELEM_MIN, ELEM_MIN), 0);
        send_matrix(diag(32'h1, 32'h1, 32'h1), 0);
        send_matrix(diag(32'h3, 32'h3, 32'hFFFFFFFD), 2);
        send_matrix(diag(32'h30000, 32'h30000, 32'h30000), 0);
        send_matrix({9{32'hFFFFFFFF}}, 0);
        send_matrix(diag(ELEM_MAX, 32'h1, ELEM_MIN), 0);
        for (int k = 0; k < 1700; k++)
        begin
            for (int e = 0; e < 9; e++)
                m[e*32 +: 32] = rand_elem();
            if ($urandom_range(0, 15) == 0)
                m[3*32 +: 96] = m[0 +: 96];   // repeated row: singular
            if (k == 300)
                sink_hold = 1;
            if (k == 900)
                while (sb.inv_q.size() != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                end
            send_matrix(m, (k > 300 && k < 400) ? 0 : gap_len());
        end
        s_axis_tvalid <= 1'b0;
        sent_all = 1;
    end

    // Sink side; one long hold-off while the source keeps sending
    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold)
            begin
                sink_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
            if (g > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_inverse(m_axis_tdata, m_axis_tuser);
        end
    end

    initial
    begin
        wait (sent_all);
        while (sb.inv_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #800000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
